// ===== sv/lpd_pkg.sv =====
// Shared types and constants for the length-prefix deframer.
package lpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int MAX_LEN_W = 17;
    localparam int WIDE_W    = 64;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 17'd8096;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_header;
        logic              packet_end;
        logic              frame_error;
        logic              dropped;
    } t_result;

endpackage

// ===== sv/lpd_in_reg.sv =====
// Input register stage: holds one received byte until the parser takes it.
module lpd_in_reg
    import lpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_stall,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte,
    input  logic              i_take
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_accept;

    // Refill in the same cycle the held byte moves on.
    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== sv/lpd_parser.sv =====
// Framing state and per-byte flag logic, plus the maximum length register.
module lpd_parser
    import lpd_pkg::*;
#(
    parameter int HEADER_BYTES = 4
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [MAX_LEN_W-1:0] i_cfg_wr_data,
    input  logic                 i_fire,
    input  logic [BYTE_W-1:0]    i_byte,
    output t_result              o_res
);

    localparam int CNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam logic [CNT_W-1:0]     LAST_POS = CNT_W'(HEADER_BYTES - 1);
    localparam logic [MAX_LEN_W-1:0] HDR_LEN  = MAX_LEN_W'(HEADER_BYTES);

    logic [MAX_LEN_W-1:0] r_max_len;
    logic                 r_in_body;
    logic [CNT_W-1:0]     r_hdr_cnt;
    logic [MAX_LEN_W-1:0] r_len_lo;
    logic                 r_len_hi;
    logic [MAX_LEN_W-1:0] r_body_rem;
    logic                 r_closed;

    logic                 n_in_body;
    logic [CNT_W-1:0]     n_hdr_cnt;
    logic [MAX_LEN_W-1:0] n_len_lo;
    logic                 n_len_hi;
    logic [MAX_LEN_W-1:0] n_body_rem;
    logic                 n_closed;

    logic [WIDE_W-1:0]    w_contrib;
    logic [MAX_LEN_W-1:0] w_len_lo;
    logic                 w_len_hi;
    logic [MAX_LEN_W-1:0] w_rem_dec;
    logic                 w_bad_len;
    t_result              w_res;

    // Place the byte at its little-endian position; bits above the register
    // width only matter as "too large".
    assign w_contrib = {{(WIDE_W-BYTE_W){1'b0}}, i_byte} << {r_hdr_cnt, 3'b000};
    assign w_len_lo  = r_len_lo | w_contrib[MAX_LEN_W-1:0];
    assign w_len_hi  = r_len_hi | (|w_contrib[WIDE_W-1:MAX_LEN_W]);
    assign w_bad_len = w_len_hi || (w_len_lo < HDR_LEN) || (w_len_lo > r_max_len);
    assign w_rem_dec = (r_body_rem != '0) ? (r_body_rem - 1'b1) : r_body_rem;

    always_comb begin
        n_in_body  = r_in_body;
        n_hdr_cnt  = r_hdr_cnt;
        n_len_lo   = r_len_lo;
        n_len_hi   = r_len_hi;
        n_body_rem = r_body_rem;
        n_closed   = r_closed;
        w_res      = '0;
        w_res.out_byte = i_byte;
        if (r_closed) begin
            w_res.dropped = 1'b1;
        end else if (r_in_body) begin
            n_body_rem = w_rem_dec;
            if (w_rem_dec == '0) begin
                w_res.packet_end = 1'b1;
                n_in_body        = 1'b0;
            end
        end else begin
            w_res.is_header = 1'b1;
            if (r_hdr_cnt == LAST_POS) begin
                n_hdr_cnt = '0;
                n_len_lo  = '0;
                n_len_hi  = 1'b0;
                if (w_bad_len) begin
                    w_res.frame_error = 1'b1;
                    n_closed          = 1'b1;
                end else if (w_len_lo == HDR_LEN) begin
                    w_res.packet_end = 1'b1;
                end else begin
                    n_body_rem = w_len_lo - HDR_LEN;
                    n_in_body  = 1'b1;
                end
            end else begin
                n_hdr_cnt = r_hdr_cnt + 1'b1;
                n_len_lo  = w_len_lo;
                n_len_hi  = w_len_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_LEN_RESET;
            r_in_body  <= 1'b0;
            r_hdr_cnt  <= '0;
            r_len_lo   <= '0;
            r_len_hi   <= 1'b0;
            r_body_rem <= '0;
            r_closed   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_in_body  <= n_in_body;
                r_hdr_cnt  <= n_hdr_cnt;
                r_len_lo   <= n_len_lo;
                r_len_hi   <= n_len_hi;
                r_body_rem <= n_body_rem;
                r_closed   <= n_closed;
            end
        end
    end

    assign o_res = w_res;

`ifndef SYNTHESIS
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_res.frame_error |=> r_closed)
        else $error("session not closed after frame error");

    a_err_is_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.frame_error |-> w_res.is_header && !w_res.packet_end)
        else $error("frame error outside a header byte");

    a_drop_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.dropped |-> !(w_res.is_header || w_res.packet_end || w_res.frame_error))
        else $error("dropped byte carries other flags");

    a_body_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> !r_closed && (r_body_rem != '0))
        else $error("body state with closed session or nothing left");
`endif

endmodule

// ===== sv/lpd_out_reg.sv =====
// Result register: holds one flagged byte until the downstream side takes it.
module lpd_out_reg
    import lpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_stall
);

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result leaves this cycle.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== sv/length_prefix_deframer_top.sv =====
// Top level of the length-prefix deframer.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+------------------------------------
//   input    | in        | i_in_valid / o_in_stall     | i_data_byte
//   output   | out       | o_out_valid / i_out_stall   | o_out_byte, o_is_header,
//            |           |                             | o_packet_end, o_frame_error, o_dropped
//   config   | in        | i_cfg_wr_en                 | i_max_packet_length
//
// One byte per cycle sustained while i_out_stall is low; a byte's result passes through the input
// register, then the parser, then the result register, which presents it.
// Reset is synchronous and clears the framing state and sets the maximum length to 8096.
// A stall on the output holds the result register; the input register then fills and
// raises o_in_stall, so at most two bytes are held inside.
module length_prefix_deframer_top
    import lpd_pkg::*;
#(
    parameter int HEADER_BYTES = 4
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [MAX_LEN_W-1:0] i_max_packet_length,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_data_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_is_header,
    output logic                 o_packet_end,
    output logic                 o_frame_error,
    output logic                 o_dropped
);

    logic              w_held_valid;
    logic [BYTE_W-1:0] w_held_byte;
    logic              w_out_free;
    logic              w_fire;
    t_result           w_res;
    t_result           w_out_res;

    assign w_fire = w_held_valid && w_out_free;

    lpd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_data_byte),
        .o_stall (o_in_stall),
        .o_valid (w_held_valid),
        .o_byte  (w_held_byte),
        .i_take  (w_fire)
    );

    lpd_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_max_packet_length),
        .i_fire        (w_fire),
        .i_byte        (w_held_byte),
        .o_res         (w_res)
    );

    lpd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_held_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_res   (w_out_res),
        .i_stall (i_out_stall)
    );

    assign o_out_byte    = w_out_res.out_byte;
    assign o_is_header   = w_out_res.is_header;
    assign o_packet_end  = w_out_res.packet_end;
    assign o_frame_error = w_out_res.frame_error;
    assign o_dropped     = w_out_res.dropped;

endmodule

// ===== verif/tb_length_prefix_deframer_top.sv =====
// Self-checking testbench for the length-prefix deframer: directed cases, random packets, then a session close.
module tb_length_prefix_deframer_top
    import lpd_pkg::*;
();

    localparam int HDR_BYTES  = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [MAX_LEN_W-1:0] i_max_packet_length;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_data_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_is_header;
    logic                 o_packet_end;
    logic                 o_frame_error;
    logic                 o_dropped;

    // Framing state mirrored from the block, at reset values
    logic [MAX_LEN_W-1:0] limit_len    = MAX_LEN_RESET;
    logic                 in_payload   = 1'b0;
    int                   hdr_count    = 0;
    logic [31:0]          length_acc   = '0;
    logic [MAX_LEN_W-1:0] payload_left = '0;
    logic                 session_closed = 1'b0;

    t_result framed_bytes_q[$];
    t_result next_due;

    int  mismatches    = 0;
    int  results_seen  = 0;
    bit  tx_gaps_on    = 1'b1;
    bit  rx_gaps_on    = 1'b1;
    int  rx_hold_left  = 0;
    int  rx_stall_left = 0;

    length_prefix_deframer_top #(
        .HEADER_BYTES(HDR_BYTES)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_max_packet_length(i_max_packet_length),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_byte         (o_out_byte),
        .o_is_header        (o_is_header),
        .o_packet_end       (o_packet_end),
        .o_frame_error      (o_frame_error),
        .o_dropped          (o_dropped)
    );

    always #4 i_clk = ~i_clk;

    // Advance the framing state by one byte and return the flags it should carry
    function automatic t_result frame_next_byte(input logic [BYTE_W-1:0] value);
        t_result     res;
        logic [31:0] hdr_len;
        res          = '0;
        res.out_byte = value;
        if (session_closed) begin
            res.dropped = 1'b1;
        end else if (in_payload) begin
            if (payload_left != 0)
                payload_left = payload_left - 1'b1;
            if (payload_left == 0) begin
                res.packet_end = 1'b1;
                in_payload     = 1'b0;
            end
        end else begin
            res.is_header = 1'b1;
            length_acc    = length_acc | (32'(value) << (8 * hdr_count));
            hdr_count++;
            if (hdr_count >= HDR_BYTES) begin
                hdr_len    = length_acc;
                hdr_count  = 0;
                length_acc = '0;
                if (hdr_len < HDR_BYTES || hdr_len > {15'd0, limit_len}) begin
                    res.frame_error = 1'b1;
                    session_closed  = 1'b1;
                end else if (hdr_len == HDR_BYTES) begin
                    res.packet_end = 1'b1;
                end else begin
                    payload_left = MAX_LEN_W'(hdr_len - HDR_BYTES);
                    in_payload   = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Mostly short idles, now and then a long one
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_packet_len(input int cap);
        int r;
        r = $urandom_range(0, 99);
        if (cap <= HDR_BYTES || r < 10)
            return HDR_BYTES;
        if (r < 20)
            return cap;
        if (r < 85)
            return $urandom_range(HDR_BYTES + 1, (cap < 40) ? cap : 40);
        return $urandom_range(HDR_BYTES + 1, cap);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    // Offer one byte from a falling edge; return at the falling edge after its transfer
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int idle;
        idle = 0;
        if (tx_gaps_on && $urandom_range(0, 2) == 0)
            idle = pick_idle_len();
        repeat (idle) @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_data_byte = value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        framed_bytes_q.push_back(frame_next_byte(value));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_packet(input int unsigned len);
        logic [31:0] word;
        word = len;
        for (int i = 0; i < HDR_BYTES; i++)
            send_byte(word[8*i +: 8]);
        for (int i = HDR_BYTES; i < len; i++)
            send_byte(BYTE_W'($urandom));
    endtask

    task automatic wait_drained();
        while (framed_bytes_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [MAX_LEN_W-1:0] value);
        wait_drained();
        i_cfg_wr_en         = 1'b1;
        i_max_packet_length = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        limit_len   = value;
    endtask

    task automatic set_idling(input bit tx, input bit rx);
        tx_gaps_on = tx;
        rx_gaps_on = rx;
    endtask

    task automatic test_empty_and_short_packets();
        set_idling(1'b1, 1'b1);
        send_packet(HDR_BYTES);
        send_byte(8'h05);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_limit_edges();
        write_limit(MAX_LEN_W'(HDR_BYTES));
        send_packet(HDR_BYTES);
        write_limit(17'd6);
        send_packet(6);
        write_limit('1);
    endtask

    // A new limit only counts from the next header onwards
    task automatic test_limit_change_mid_packet();
        send_byte(8'h06);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        write_limit(MAX_LEN_W'(HDR_BYTES));
        send_byte(8'h00);
        send_packet(HDR_BYTES);
    endtask

    // Hold the output long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        wait_drained();
        write_limit(MAX_LEN_RESET);
        set_idling(1'b0, 1'b0);
        rx_hold_left = 200;
        repeat (3) send_packet(12);
        wait_drained();
        set_idling(1'b1, 1'b1);
    endtask

    // A packet exactly at the limit, sent without gaps
    task automatic test_longest_packet();
        write_limit(17'd200);
        set_idling(1'b0, 1'b0);
        send_packet(200);
    endtask

    task automatic test_random_packets();
        int                   sent;
        int                   phase_end;
        int                   cap;
        int                   len;
        logic [MAX_LEN_W-1:0] lim;
        sent = 0;
        while (sent < 200) begin
            case ($urandom_range(0, 4))
                0: lim = '1;
                1: lim = 17'd65536;
                2: lim = MAX_LEN_RESET;
                3: lim = MAX_LEN_W'($urandom_range(300, 65536));
                default: lim = MAX_LEN_W'($urandom_range(HDR_BYTES, 40));
            endcase
            write_limit(lim);
            set_idling(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            cap       = (lim > 300) ? 300 : int'(lim);
            phase_end = sent + $urandom_range(40, 120);
            while (sent < phase_end) begin
                len = pick_packet_len(cap);
                send_packet(len);
                sent += len;
            end
        end
    endtask

    // Close the session with a zero limit and a too-short length, then check that all is dropped
    task automatic test_session_close();
        write_limit('0);
        set_idling(1'b1, 1'b1);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        repeat (28) send_byte(BYTE_W'($urandom));
        write_limit(MAX_LEN_RESET);
        send_packet(6);
    endtask

    initial begin : out_stall_driver
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_stall = 1'b1;
                rx_hold_left--;
            end else if (rx_stall_left > 0) begin
                i_out_stall = 1'b1;
                rx_stall_left--;
            end else begin
                i_out_stall = 1'b0;
                if (rx_gaps_on && $urandom_range(0, 3) == 0)
                    rx_stall_left = pick_idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (framed_bytes_q.size() == 0) begin
                report_mismatch($sformatf("byte %02h with no transfer outstanding", o_out_byte));
            end else begin
                next_due = framed_bytes_q.pop_front();
                if (o_out_byte !== next_due.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              o_out_byte, next_due.out_byte));
                if (o_is_header !== next_due.is_header)
                    report_mismatch($sformatf("is_header %b, want %b",
                                              o_is_header, next_due.is_header));
                if (o_packet_end !== next_due.packet_end)
                    report_mismatch($sformatf("packet_end %b, want %b",
                                              o_packet_end, next_due.packet_end));
                if (o_frame_error !== next_due.frame_error)
                    report_mismatch($sformatf("frame_error %b, want %b",
                                              o_frame_error, next_due.frame_error));
                if (o_dropped !== next_due.dropped)
                    report_mismatch($sformatf("dropped %b, want %b",
                                              o_dropped, next_due.dropped));
            end
            results_seen++;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_max_packet_length = MAX_LEN_RESET;
        i_in_valid          = 1'b0;
        i_data_byte         = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_and_short_packets();
        test_limit_edges();
        test_limit_change_mid_packet();
        test_output_backpressure();
        test_longest_packet();
        test_random_packets();
        test_session_close();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : run_limit
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
